[src/ctfm_pkg.sv]
`default_nettype none

package ctfm_pkg;

    localparam int NUM_BANKS        = 8;
    localparam int SENSORS_PER_BANK = 32;
    localparam int TOTAL_SENSORS    = NUM_BANKS * SENSORS_PER_BANK;
    localparam int IDX_W            = (TOTAL_SENSORS > 1) ? $clog2(TOTAL_SENSORS) : 1;

    localparam int BANK_W   = 3;
    localparam int SENSOR_W = 5;
    localparam int TEMP_W   = 12;
    localparam int LIMIT_W  = 11;
    localparam int LEVEL_W  = 8;
    localparam int TOTAL_W  = 9;
    localparam int CFG_W    = 11;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    // coverage test: valid * 5 < total sensors, i.e. below one fifth
    localparam int COVER_W  = 12;
    localparam logic [COVER_W-1:0] COVER_LIMIT = COVER_W'(TOTAL_SENSORS);

    localparam logic signed [TEMP_W-1:0] INVALID_TEMP = -12;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [LIMIT_W-1:0] MAX_TEMP_RESET    = 11'd600;
    localparam logic [LIMIT_W-1:0] MIN_TEMP_RESET    = 11'd0;
    localparam logic [LEVEL_W-1:0] FAULT_COUNT_RESET = 8'd10;

    typedef enum logic [1:0] {
        CFG_MAX_TEMP    = 2'd0,
        CFG_MIN_TEMP    = 2'd1,
        CFG_FAULT_COUNT = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

[src/cell_temperature_fault_monitor.sv]
// cell temperature fault monitor
//
// input stream (s_*): one temperature reading per word, bank and sensor
// address plus signed deci-degree value; s_tlast marks the last reading
// of a scan. a reading of -12 is the invalid marker and is not counted.
// output stream (m_*): one result word per reading, in order.
// config port: cfg_we / cfg_index / cfg_data write max limit, min limit
// and fault count; write only while no reading is in flight.
//
// pipeline: a reading is registered in the compute stage on accept, then
// its result in the output register. throughput: one word per cycle while m_tready is high;
// the per-sensor counter table is a single-port-read,
// single-port-write ram doing one read-modify-write per word, with
// forwarding from the write-back stage to the following read.
// reset (aresetn low, synchronous): limits return to 600 / 0 / 10, the
// scan count clears and every table entry reads as zero through per-entry
// valid flags, so no clearing pass is needed.
// when m_tready is low the result is held, the compute stage fills and
// then s_tready drops; nothing is lost or repeated.
`default_nettype none

module cell_temperature_fault_monitor
    import ctfm_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_tvalid,
    output logic                s_tready,
    // [2:0] bank_index, [7:3] sensor_index, [19:8] temp_dc, [23:20] zero
    input  wire  [IN_W-1:0]     s_tdata,
    input  wire                 s_tlast,

    output logic                m_tvalid,
    input  wire                 m_tready,
    // [0] reading_valid, [1] out_of_window, [9:2] violation_level,
    // [10] temp_fault, [11] coverage_fault, [20:12] valid_total, [23:21] zero
    output logic [OUT_W-1:0]    m_tdata,

    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [CFG_W-1:0]    cfg_data
);

    // configuration registers
    logic [LIMIT_W-1:0] max_temp_reg;
    logic [LIMIT_W-1:0] min_temp_reg;
    logic [LEVEL_W-1:0] fault_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_temp_reg    <= MAX_TEMP_RESET;
            min_temp_reg    <= MIN_TEMP_RESET;
            fault_count_reg <= FAULT_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MAX_TEMP:    max_temp_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_MIN_TEMP:    min_temp_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_FAULT_COUNT: fault_count_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // input decode
    logic [BANK_W-1:0]        in_bank;
    logic [SENSOR_W-1:0]      in_sensor;
    logic signed [TEMP_W-1:0] in_temp;
    logic                     in_range;
    logic [IDX_W-1:0]         in_idx;
    logic                     s_accept;

    assign in_bank   = s_tdata[BANK_W-1:0];
    assign in_sensor = s_tdata[BANK_W+SENSOR_W-1:BANK_W];
    assign in_temp   = s_tdata[BANK_W+SENSOR_W+TEMP_W-1:BANK_W+SENSOR_W];
    assign in_range  = (int'(in_bank) < NUM_BANKS) && (int'(in_sensor) < SENSORS_PER_BANK);
    assign in_idx    = in_range
                     ? IDX_W'(int'(in_bank) * SENSORS_PER_BANK + int'(in_sensor))
                     : '0;
    assign s_accept  = s_tvalid && s_tready;

    // compute stage registers
    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic                     s1_range_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s1_last_reg;
    logic                     fwd_hit_reg;
    logic [LEVEL_W-1:0]       fwd_data_reg;

    // output register
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_data_reg;

    logic                     s1_advance;
    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;

    // counter table with per-entry valid flags for the reset value
    logic [LEVEL_W-1:0]       count_mem [TOTAL_SENSORS];
    logic [TOTAL_SENSORS-1:0] entry_valid_reg;
    logic [LEVEL_W-1:0]       mem_q_reg;
    logic                     entry_q_reg;

    logic                     wr_en;
    logic [LEVEL_W-1:0]       wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem[s1_idx_reg] <= wr_data;
        end
        if (s_accept) begin
            mem_q_reg <= count_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            entry_q_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                entry_valid_reg[s1_idx_reg] <= 1'b1;
            end
            if (s_accept) begin
                entry_q_reg <= entry_valid_reg[in_idx];
            end
        end
    end

    // stage 0 -> stage 1, with forwarding from the write-back going out now
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s1_idx_reg == in_idx);
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg   <= in_idx;
            s1_range_reg <= in_range;
            s1_temp_reg  <= in_temp;
            s1_last_reg  <= s_tlast;
            fwd_data_reg <= wr_data;
        end
    end

    // compute
    logic                       rd_valid;
    logic                       rd_oow;
    logic [LEVEL_W-1:0]         stored_level;
    logic [LEVEL_W-1:0]         level_next;
    logic [LEVEL_W-1:0]         level_out;
    logic                       rd_tfault;
    logic                       rd_cfault;
    logic signed [TEMP_W:0]     temp_ext;
    logic signed [TEMP_W:0]     max_ext;
    logic signed [TEMP_W:0]     min_ext;
    logic [TOTAL_W-1:0]         scan_count_reg;
    logic [TOTAL_W-1:0]         scan_count_next;
    logic [TOTAL_W-1:0]         total;
    logic [COVER_W-1:0]         total_x5;

    assign temp_ext = {s1_temp_reg[TEMP_W-1], s1_temp_reg};
    assign max_ext  = signed'({{(TEMP_W+1-LIMIT_W){1'b0}}, max_temp_reg});
    assign min_ext  = signed'({{(TEMP_W+1-LIMIT_W){1'b0}}, min_temp_reg});

    always_comb begin
        rd_valid     = s1_temp_reg != INVALID_TEMP;
        rd_oow       = rd_valid && ((temp_ext > max_ext) || (temp_ext < min_ext));
        stored_level = fwd_hit_reg ? fwd_data_reg : (entry_q_reg ? mem_q_reg : '0);
        level_next   = stored_level;
        rd_tfault    = 1'b0;
        if (rd_oow) begin
            if (stored_level != LEVEL_MAX) begin
                level_next = stored_level + LEVEL_W'(1);
                rd_tfault  = level_next == fault_count_reg;
            end
        end else begin
            level_next = '0;
        end
        if (!rd_valid) begin
            level_next = stored_level;
            rd_tfault  = 1'b0;
        end
        if (!s1_range_reg) begin
            rd_tfault = 1'b0;
        end
        level_out = s1_range_reg ? level_next : '0;

        // scan coverage, count saturates
        total = (rd_valid && scan_count_reg != TOTAL_MAX)
              ? scan_count_reg + TOTAL_W'(1) : scan_count_reg;
        total_x5  = (COVER_W'(total) << 2) + COVER_W'(total);
        rd_cfault = s1_last_reg && (total_x5 < COVER_LIMIT);
        scan_count_next = s1_last_reg ? '0 : total;
    end

    assign wr_en   = s1_valid_reg && s1_advance && rd_valid && s1_range_reg;
    assign wr_data = level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s1_valid_reg && s1_advance) begin
                scan_count_reg <= scan_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_advance) begin
            m_data_reg <= {3'b000, total, rd_cfault, rd_tfault, level_out, rd_oow, rd_valid};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    // an empty output register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // a write-back to the entry being read must be forwarded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && wr_en && (s1_idx_reg == in_idx)) |=> fwd_hit_reg)
        else $error("missed forwarding on same-entry access");

    // a temperature fault only comes from a valid out-of-window reading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[1] && m_tdata[0]))
        else $error("temp fault without out-of-window reading");

    // invalid readings are never out of window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> !m_tdata[1])
        else $error("invalid reading flagged out of window");

    // the table is only written when a result moves to the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid_reg)
        else $error("table write without result");
`endif

endmodule

`default_nettype wire
